### sv/d2q9_bgk_pkg.sv
`default_nettype none

package d2q9_bgk_pkg;

    // Lattice geometry and field widths
    localparam int DIRS   = 9;
    localparam int F_W    = 32;
    localparam int RATE_W = 26;
    localparam int SUM_W  = 40;
    localparam int CNT_W  = 17;
    localparam int W_W    = 23;

    // Internal arithmetic widths
    localparam int RHO_W  = 37;
    localparam int MOM_W  = 35;
    localparam int WR_W   = 37;
    localparam int BR_W   = 46;
    localparam int MUL_W  = 48;
    localparam int PROD_W = 96;
    localparam int SQ_W   = 64;
    localparam int K_W    = 4;
    localparam int FRAC_W = 24;

    // The fluid count saturates at the smaller of the cell limit and the counter range
    localparam int MAX_CELLS = 65536;
    localparam int CNT_LIMIT = (MAX_CELLS < (2 ** CNT_W) - 1) ? MAX_CELLS : (2 ** CNT_W) - 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CNT_LIMIT);
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Relaxation rate after reset: 1.0 in Q2.24
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(16777216);

    // Equilibrium weights in Q.24
    localparam logic [W_W-1:0] W_REST = W_W'(7456540);
    localparam logic [W_W-1:0] W_AXIS = W_W'(1864135);
    localparam logic [W_W-1:0] W_DIAG = W_W'(466034);

    // One cell as it waits between the front and the back
    typedef struct packed {
        logic [DIRS-1:0][F_W-1:0] f;
        logic                     obstacle;
        logic                     start;
    } t_cell;

    // One finished result item
    typedef struct packed {
        logic [CNT_W-1:0]         fluid_count;
        logic [SUM_W-1:0]         speed_sum;
        logic [DIRS-1:0][F_W-1:0] f;
    } t_result;

    // Request to the shared multiplier
    typedef struct packed {
        logic                    go;
        logic signed [MUL_W-1:0] a;
        logic signed [MUL_W-1:0] b;
    } t_mul_req;

    // Request to the divider
    typedef struct packed {
        logic                    go;
        logic signed [MOM_W-1:0] num;
        logic signed [RHO_W-1:0] den;
    } t_div_req;

    // Direction whose value a bounced-back direction takes
    function automatic logic [K_W-1:0] bounce_src(input logic [K_W-1:0] k);
        logic [K_W-1:0] s;
        case (k)
            4'd1:    s = 4'd3;
            4'd2:    s = 4'd4;
            4'd3:    s = 4'd1;
            4'd4:    s = 4'd2;
            4'd5:    s = 4'd7;
            4'd6:    s = 4'd8;
            4'd7:    s = 4'd5;
            4'd8:    s = 4'd6;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

    // Lattice velocity x component of a direction
    function automatic logic signed [1:0] cdir_x(input logic [K_W-1:0] k);
        logic signed [1:0] c;
        case (k)
            4'd1, 4'd5, 4'd8: c = 2'sd1;
            4'd3, 4'd6, 4'd7: c = -2'sd1;
            default:          c = 2'sd0;
        endcase
        return c;
    endfunction

    // Lattice velocity y component of a direction
    function automatic logic signed [1:0] cdir_y(input logic [K_W-1:0] k);
        logic signed [1:0] c;
        case (k)
            4'd2, 4'd5, 4'd6: c = 2'sd1;
            4'd4, 4'd7, 4'd8: c = -2'sd1;
            default:          c = 2'sd0;
        endcase
        return c;
    endfunction

    // Equilibrium weight of a direction
    function automatic logic [W_W-1:0] weight(input logic [K_W-1:0] k);
        logic [W_W-1:0] w;
        case (k)
            4'd0:                   w = W_REST;
            4'd1, 4'd2, 4'd3, 4'd4: w = W_AXIS;
            default:                w = W_DIAG;
        endcase
        return w;
    endfunction

    // Clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [F_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        logic signed [F_W-1:0]    r;
        hi = PROD_W'(64'sd2147483647);
        lo = PROD_W'(-64'sd2147483648);
        if (v > hi) begin
            r = 32'sh7fffffff;
        end else if (v < lo) begin
            r = 32'sh80000000;
        end else begin
            r = signed'(v[F_W-1:0]);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/d2q9_bgk_mul.sv
`default_nettype none

// Shared signed multiplier: magnitudes are multiplied one 16-bit digit of b per cycle,
// most significant digit first, and the sign is applied in a final cycle.
module d2q9_bgk_mul (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  d2q9_bgk_pkg::t_mul_req                   i_req,
    output logic                                     o_done,
    output logic signed [d2q9_bgk_pkg::PROD_W-1:0]   o_prod
);

    localparam int MW      = d2q9_bgk_pkg::MUL_W;
    localparam int PW      = d2q9_bgk_pkg::PROD_W;
    localparam int DIGIT_W = 16;
    localparam int STEPS   = MW / DIGIT_W;
    localparam int CW      = $clog2(STEPS);

    logic [MW-1:0]     r_a;
    logic [MW-1:0]     r_b;
    logic              r_neg;
    logic [PW-1:0]     r_acc;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_fin;
    logic              r_done;
    logic signed [PW-1:0] r_prod;

    logic [MW+DIGIT_W-1:0] part;

    // One partial product per cycle
    assign part = r_a * r_b[MW-1 -: DIGIT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_fin  <= !i_req.go && r_busy && (r_cnt == CW'(STEPS - 1));
            r_done <= r_fin;
            if (i_req.go) begin
                r_a    <= i_req.a[MW-1] ? MW'(-i_req.a) : MW'(i_req.a);
                r_b    <= i_req.b[MW-1] ? MW'(-i_req.b) : MW'(i_req.b);
                r_neg  <= i_req.a[MW-1] ^ i_req.b[MW-1];
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= (r_acc << DIGIT_W) + PW'(part);
                r_b   <= r_b << DIGIT_W;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
            // Apply the sign of the product
            if (r_fin) begin
                r_prod <= r_neg ? -signed'(r_acc) : signed'(r_acc);
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

`default_nettype wire

### sv/d2q9_bgk_div.sv
`default_nettype none

// Restoring divider for the velocity: (num * 2^24) / den, truncated toward zero,
// one quotient bit per cycle, then clamped to the signed 32-bit range.
module d2q9_bgk_div (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  d2q9_bgk_pkg::t_div_req                 i_req,
    output logic                                   o_done,
    output logic signed [d2q9_bgk_pkg::F_W-1:0]    o_quot
);

    localparam int NW    = d2q9_bgk_pkg::MOM_W;
    localparam int DW    = d2q9_bgk_pkg::RHO_W;
    localparam int FW    = d2q9_bgk_pkg::F_W;
    localparam int DVD_W = NW + d2q9_bgk_pkg::FRAC_W;
    localparam int REM_W = DW + 1;
    localparam int CW    = $clog2(DVD_W);

    logic [DVD_W-1:0] r_dvd;
    logic [DW-1:0]    r_den;
    logic [REM_W-1:0] r_rem;
    logic [DVD_W-1:0] r_quot;
    logic [CW-1:0]    r_cnt;
    logic             r_neg;
    logic             r_busy;
    logic             r_fin;
    logic             r_done;
    logic signed [FW-1:0] r_q;

    logic [NW-1:0]    num_mag;
    logic [REM_W-1:0] trial;
    logic             fits;

    assign num_mag = i_req.num[NW-1] ? NW'(-i_req.num) : NW'(i_req.num);
    assign trial   = {r_rem[REM_W-2:0], r_dvd[DVD_W-1]};
    assign fits    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_fin  <= !i_req.go && r_busy && (r_cnt == CW'(DVD_W - 1));
            r_done <= r_fin;
            if (i_req.go) begin
                r_dvd  <= {num_mag, {d2q9_bgk_pkg::FRAC_W{1'b0}}};
                r_den  <= i_req.den[DW-1] ? DW'(-i_req.den) : DW'(i_req.den);
                r_neg  <= i_req.num[NW-1] ^ i_req.den[DW-1];
                r_rem  <= '0;
                r_quot <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // One restoring step
                r_rem  <= fits ? trial - {1'b0, r_den} : trial;
                r_quot <= {r_quot[DVD_W-2:0], fits};
                r_dvd  <= r_dvd << 1;
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CW'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
            // Sign and clamp the quotient
            if (r_fin) begin
                if (r_neg) begin
                    r_q <= (r_quot > DVD_W'(64'd2147483648)) ? 32'sh80000000
                                                             : -signed'(r_quot[FW-1:0]);
                end else begin
                    r_q <= (r_quot > DVD_W'(64'd2147483647)) ? 32'sh7fffffff
                                                             : signed'(r_quot[FW-1:0]);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

### sv/d2q9_bgk_front.sv
`default_nettype none

// Front end: accepts cells, applies bounce-back to obstacle cells at once and
// holds them in a two-entry queue until the back end takes them.
module d2q9_bgk_front (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_valid,
    output logic                           o_ready,
    input  wire  [d2q9_bgk_pkg::DIRS-1:0][d2q9_bgk_pkg::F_W-1:0] i_f,
    input  wire                            i_obstacle,
    input  wire                            i_start,
    output logic                           o_cell_valid,
    output d2q9_bgk_pkg::t_cell            o_cell,
    input  wire                            i_pop
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    d2q9_bgk_pkg::t_cell r_q [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;

    d2q9_bgk_pkg::t_cell entry;
    logic push;
    logic pop;

    // Classify the cell: obstacles are bounced back here
    always_comb begin
        entry.obstacle = i_obstacle;
        entry.start    = i_start;
        for (int k = 0; k < d2q9_bgk_pkg::DIRS; k++) begin
            entry.f[k] = i_obstacle ? i_f[d2q9_bgk_pkg::bounce_src(d2q9_bgk_pkg::K_W'(k))]
                                    : i_f[k];
        end
    end

    assign o_ready      = r_count != CW'(DEPTH);
    assign push         = i_valid && o_ready;
    assign o_cell_valid = r_count != '0;
    assign pop          = i_pop && o_cell_valid;
    assign o_cell       = r_q[r_rd];

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= entry;
        end
    end

    // Queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### sv/d2q9_bgk_back.sv
`default_nettype none

// Back end: a sequencer that relaxes one fluid cell at a time with a shared
// multiplier, a divider and a bit-pair square root, keeps the running totals
// and holds the finished item in an output register.
module d2q9_bgk_back (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_cell_valid,
    input  d2q9_bgk_pkg::t_cell                     i_cell,
    output logic                                    o_pop,
    input  wire  [d2q9_bgk_pkg::RATE_W-1:0]         i_relax_rate,
    output logic                                    o_valid,
    input  wire                                     i_ready,
    output d2q9_bgk_pkg::t_result                   o_result
);

    localparam int DIRS  = d2q9_bgk_pkg::DIRS;
    localparam int FW    = d2q9_bgk_pkg::F_W;
    localparam int RW    = d2q9_bgk_pkg::RHO_W;
    localparam int MOW   = d2q9_bgk_pkg::MOM_W;
    localparam int MW    = d2q9_bgk_pkg::MUL_W;
    localparam int PW    = d2q9_bgk_pkg::PROD_W;
    localparam int BW    = d2q9_bgk_pkg::BR_W;
    localparam int WRW   = d2q9_bgk_pkg::WR_W;
    localparam int SQW   = d2q9_bgk_pkg::SQ_W;
    localparam int KW    = d2q9_bgk_pkg::K_W;
    localparam int FRAC  = d2q9_bgk_pkg::FRAC_W;
    localparam int SW    = d2q9_bgk_pkg::SUM_W;
    localparam int CNW   = d2q9_bgk_pkg::CNT_W;
    localparam int T_W   = 2 * FW - 1 - FRAC;
    localparam int H_W   = SQW - FRAC + 2;

    // Sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SUM    = 4'd1;
    localparam logic [3:0] ST_DIVX   = 4'd2;
    localparam logic [3:0] ST_DIVY   = 4'd3;
    localparam logic [3:0] ST_USTART = 4'd4;
    localparam logic [3:0] ST_SQX    = 4'd5;
    localparam logic [3:0] ST_SQY    = 4'd6;
    localparam logic [3:0] ST_SQRT   = 4'd7;
    localparam logic [3:0] ST_CU     = 4'd8;
    localparam logic [3:0] ST_T      = 4'd9;
    localparam logic [3:0] ST_WR     = 4'd10;
    localparam logic [3:0] ST_FEQ    = 4'd11;
    localparam logic [3:0] ST_DIFF   = 4'd12;
    localparam logic [3:0] ST_RELAX  = 4'd13;
    localparam logic [3:0] ST_DONE   = 4'd14;

    logic [3:0]                r_state;
    logic [DIRS-1:0][FW-1:0]   r_f;
    logic [DIRS-1:0][FW-1:0]   r_res;
    logic signed [RW-1:0]      r_rho;
    logic signed [MOW-1:0]     r_my;
    logic signed [FW-1:0]      r_ux;
    logic signed [FW-1:0]      r_uy;
    logic [SQW-1:0]            r_sq;
    logic [SQW-1:0]            r_sv;
    logic [SQW-1:0]            r_root;
    logic [SQW-1:0]            r_bit;
    logic [H_W-1:0]            r_half3;
    logic [KW-1:0]             r_k;
    logic signed [FW-1:0]      r_cu;
    logic signed [BW-1:0]      r_br;
    logic signed [FW-1:0]      r_feq;
    logic [SW-1:0]             r_acc;
    logic [CNW-1:0]            r_cnt;
    logic                      r_ovalid;
    d2q9_bgk_pkg::t_result     r_out;

    logic                      r_mul_go;
    logic signed [MW-1:0]      r_mul_a;
    logic signed [MW-1:0]      r_mul_b;
    logic                      r_div_go;
    logic signed [MOW-1:0]     r_div_num;
    logic signed [RW-1:0]      r_div_den;

    d2q9_bgk_pkg::t_mul_req    mul_req;
    d2q9_bgk_pkg::t_div_req    div_req;
    logic                      mul_done;
    logic signed [PW-1:0]      prod;
    logic signed [PW-1:0]      prod_q24;
    logic                      div_done;
    logic signed [FW-1:0]      div_quot;
    logic                      load_out;

    logic signed [RW-1:0]      rho_sum;
    logic signed [MOW-1:0]     mx_sum;
    logic signed [MOW-1:0]     my_sum;
    logic signed [FW+1:0]      cu_full;
    logic signed [FW-1:0]      cu_sat;
    logic [T_W-1:0]            t_val;
    logic [T_W+3:0]            t9;
    logic [SQW-FRAC-1:0]       usq;
    logic [H_W:0]              usq3;
    logic signed [BW-1:0]      cu3;
    logic signed [BW-1:0]      bracket;
    logic [SQW-1:0]            sq_total;
    logic [SQW-1:0]            sqrt_trial;
    logic [SW:0]               acc_sum;
    logic signed [FW-1:0]      f_k;
    logic signed [MW-1:0]      wr_now;
    logic signed [MW-1:0]      omega;
    logic signed [MW-1:0]      diff;
    logic signed [PW-1:0]      relax_sum;

    assign mul_req = '{go: r_mul_go, a: r_mul_a, b: r_mul_b};
    assign div_req = '{go: r_div_go, num: r_div_num, den: r_div_den};

    d2q9_bgk_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    d2q9_bgk_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Density and momenta of the held cell
    always_comb begin
        rho_sum = '0;
        for (int i = 0; i < DIRS; i++) begin
            rho_sum = rho_sum + RW'(signed'(r_f[i]));
        end
        mx_sum = MOW'(signed'(r_f[1])) + MOW'(signed'(r_f[5])) + MOW'(signed'(r_f[8]))
               - MOW'(signed'(r_f[3])) - MOW'(signed'(r_f[6])) - MOW'(signed'(r_f[7]));
        my_sum = MOW'(signed'(r_f[2])) + MOW'(signed'(r_f[5])) + MOW'(signed'(r_f[6]))
               - MOW'(signed'(r_f[4])) - MOW'(signed'(r_f[7])) - MOW'(signed'(r_f[8]));
    end

    // Projection of the velocity on the current direction
    always_comb begin
        cu_full = '0;
        if (d2q9_bgk_pkg::cdir_x(r_k) == 2'sd1) begin
            cu_full = cu_full + (FW+2)'(r_ux);
        end else if (d2q9_bgk_pkg::cdir_x(r_k) == -2'sd1) begin
            cu_full = cu_full - (FW+2)'(r_ux);
        end
        if (d2q9_bgk_pkg::cdir_y(r_k) == 2'sd1) begin
            cu_full = cu_full + (FW+2)'(r_uy);
        end else if (d2q9_bgk_pkg::cdir_y(r_k) == -2'sd1) begin
            cu_full = cu_full - (FW+2)'(r_uy);
        end
        cu_sat = d2q9_bgk_pkg::sat32(PW'(cu_full));
    end

    // Equilibrium bracket: 1 + 3cu + 4.5cu^2 - 1.5|u|^2
    assign t_val   = prod[2*FW-2:FRAC];
    assign t9      = ({t_val, 3'b000} + (T_W+4)'(t_val)) >> 1;
    assign cu3     = (BW'(r_cu) <<< 1) + BW'(r_cu);
    assign bracket = BW'(64'sd16777216) + cu3 + signed'(BW'(t9)) - signed'(BW'(r_half3));

    // Square of the speed and its scaled forms
    assign sq_total   = r_sq + prod[SQW-1:0];
    assign usq        = r_sq[SQW-1:FRAC];
    assign usq3       = ({usq, 1'b0} + (H_W+1)'(usq)) >> 1;
    assign sqrt_trial = r_root + r_bit;
    assign acc_sum    = {1'b0, r_acc} + (SW+1)'(r_root[FW-1:0]);

    // Operands for the relaxation steps
    assign prod_q24  = prod >>> FRAC;
    assign f_k       = signed'(r_f[r_k]);
    assign wr_now    = MW'(signed'(prod[FRAC+WRW-1:FRAC]));
    assign omega     = MW'(signed'({1'b0, i_relax_rate}));
    assign diff      = MW'(r_feq) - MW'(f_k);
    assign relax_sum = PW'(f_k) + prod_q24;

    assign o_pop    = (r_state == ST_IDLE) && i_cell_valid;
    assign load_out = (r_state == ST_DONE) && (!r_ovalid || i_ready);

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_mul_go <= 1'b0;
            r_div_go <= 1'b0;
            r_ovalid <= 1'b0;
            r_acc    <= '0;
            r_cnt    <= '0;
            r_k      <= '0;
        end else begin
            // Start the multiplier or the divider once its operands are set up
            r_mul_go <= (r_state == ST_USTART) || (r_state == ST_CU) || (r_state == ST_DIFF)
                     || (mul_done && (r_state inside {ST_SQX, ST_T, ST_WR}));
            r_div_go <= ((r_state == ST_SUM) && (rho_sum != '0))
                     || ((r_state == ST_DIVX) && div_done);
            // The output register fills from a finished item and empties when taken
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_cell_valid) begin
                        r_f <= i_cell.f;
                        if (i_cell.start) begin
                            r_acc <= '0;
                            r_cnt <= '0;
                        end
                        if (i_cell.obstacle) begin
                            r_res   <= i_cell.f;
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_SUM;
                        end
                    end
                end
                ST_SUM: begin
                    r_rho <= rho_sum;
                    r_my  <= my_sum;
                    if (rho_sum == '0) begin
                        r_ux    <= '0;
                        r_uy    <= '0;
                        r_state <= ST_USTART;
                    end else begin
                        r_div_num <= mx_sum;
                        r_div_den <= rho_sum;
                        r_state   <= ST_DIVX;
                    end
                end
                ST_DIVX: begin
                    if (div_done) begin
                        r_ux      <= div_quot;
                        r_div_num <= r_my;
                        r_div_den <= r_rho;
                        r_state   <= ST_DIVY;
                    end
                end
                ST_DIVY: begin
                    if (div_done) begin
                        r_uy    <= div_quot;
                        r_state <= ST_USTART;
                    end
                end
                ST_USTART: begin
                    r_mul_a  <= MW'(r_ux);
                    r_mul_b  <= MW'(r_ux);
                    r_state  <= ST_SQX;
                end
                ST_SQX: begin
                    if (mul_done) begin
                        r_sq     <= prod[SQW-1:0];
                        r_mul_a  <= MW'(r_uy);
                        r_mul_b  <= MW'(r_uy);
                        r_state  <= ST_SQY;
                    end
                end
                ST_SQY: begin
                    if (mul_done) begin
                        r_sq    <= sq_total;
                        r_sv    <= sq_total;
                        r_root  <= '0;
                        r_bit   <= SQW'(1) << (SQW - 2);
                        r_state <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    r_half3 <= usq3[H_W-1:0];
                    if (r_bit == '0) begin
                        // Speed is ready: update the running totals
                        r_acc <= acc_sum[SW] ? d2q9_bgk_pkg::SUM_MAX : acc_sum[SW-1:0];
                        if (r_cnt < d2q9_bgk_pkg::CNT_MAX) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        r_k     <= '0;
                        r_state <= ST_CU;
                    end else begin
                        if (r_sv >= sqrt_trial) begin
                            r_sv   <= r_sv - sqrt_trial;
                            r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                ST_CU: begin
                    r_cu     <= cu_sat;
                    r_mul_a  <= MW'(cu_sat);
                    r_mul_b  <= MW'(cu_sat);
                    r_state  <= ST_T;
                end
                ST_T: begin
                    if (mul_done) begin
                        r_br     <= bracket;
                        r_mul_a  <= MW'(signed'({1'b0, d2q9_bgk_pkg::weight(r_k)}));
                        r_mul_b  <= MW'(r_rho);
                        r_state  <= ST_WR;
                    end
                end
                ST_WR: begin
                    if (mul_done) begin
                        r_mul_a  <= wr_now;
                        r_mul_b  <= MW'(r_br);
                        r_state  <= ST_FEQ;
                    end
                end
                ST_FEQ: begin
                    if (mul_done) begin
                        r_feq   <= d2q9_bgk_pkg::sat32(prod_q24);
                        r_state <= ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    r_mul_a  <= omega;
                    r_mul_b  <= diff;
                    r_state  <= ST_RELAX;
                end
                ST_RELAX: begin
                    if (mul_done) begin
                        r_res[r_k] <= d2q9_bgk_pkg::sat32(relax_sum);
                        if (r_k == KW'(DIRS - 1)) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= ST_CU;
                        end
                    end
                end
                ST_DONE: begin
                    // Hand the item to the output register once it is free
                    if (load_out) begin
                        r_out.f           <= r_res;
                        r_out.speed_sum   <= r_acc;
                        r_out.fluid_count <= r_cnt;
                        r_state           <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid  = r_ovalid;
    assign o_result = r_out;

endmodule

`default_nettype wire

### sv/d2q9_bgk_collision_core.sv
`default_nettype none

// D2Q9 BGK collision core, one lattice cell per item.
// Input channel (i_s_*): nine Q8.24 distributions in tdata, flags in tuser.
// Output channel (o_m_*): nine new distributions, the running speed sum and the
// running fluid-cell count. Configuration channel (i_cfg_*): the relaxation rate
// omega in Q2.24; it is always ready. The user must see that it is written only while
// the core is idle; the core itself does not enforce this. Obstacle cells are bounced
// back by the front end and reach the output register through the queue and back end.
// A fluid cell occupies the back end for two divisions (skipped at zero density), a
// bit-pair square root and 38 multiplications on the one shared multiplier.
// A two-entry queue sits between front and back, so up to two further cells are
// accepted while one is worked on, and an output register lets the back end start
// the next cell while a result waits. When the receiver stalls the result is held
// and the back end waits after finishing its next cell; the queue then fills and
// o_s_tready falls. Reset empties the queue, clears both running totals and sets
// omega to 1.0.
module d2q9_bgk_collision_core (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // Cell input
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    input  wire  [287:0] i_s_tdata,   // in_rest, in_east, in_north, in_west, in_south,
                                      // in_northeast, in_northwest, in_southwest,
                                      // in_southeast (32 bits each)
    input  wire  [1:0]   i_s_tuser,   // is_obstacle, start_of_grid
    // Result output
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    output logic [351:0] o_m_tdata,   // out_rest .. out_southeast (32 bits each),
                                      // speed_sum (40), fluid_count (17), zero fill
    // Relaxation rate write
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [d2q9_bgk_pkg::RATE_W-1:0] i_cfg_data
);

    localparam int DIRS = d2q9_bgk_pkg::DIRS;
    localparam int FW   = d2q9_bgk_pkg::F_W;
    localparam int RES_W = DIRS * FW + d2q9_bgk_pkg::SUM_W + d2q9_bgk_pkg::CNT_W;

    logic [d2q9_bgk_pkg::RATE_W-1:0] r_relax_rate;
    logic                            queued_valid;
    d2q9_bgk_pkg::t_cell             queued;
    logic                            pop;
    d2q9_bgk_pkg::t_result           result;

    // Relaxation rate register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relax_rate <= d2q9_bgk_pkg::RATE_RESET;
        end else if (i_cfg_valid) begin
            r_relax_rate <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    d2q9_bgk_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_f          (i_s_tdata[DIRS*FW-1:0]),
        .i_obstacle   (i_s_tuser[0]),
        .i_start      (i_s_tuser[1]),
        .o_cell_valid (queued_valid),
        .o_cell       (queued),
        .i_pop        (pop)
    );

    d2q9_bgk_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cell_valid (queued_valid),
        .i_cell       (queued),
        .o_pop        (pop),
        .i_relax_rate (r_relax_rate),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_result     (result)
    );

    // Distributions in the low bits, then the totals, then zero fill
    assign o_m_tdata = {{(352 - RES_W){1'b0}}, result};

endmodule

`default_nettype wire

### sim/tb_d2q9_bgk_collision_core.sv
`default_nettype none

module tb_d2q9_bgk_collision_core;

    localparam int  LIMIT_CYCLES = 4000000;
    localparam int  SETTLE       = 20;
    localparam longint Q24       = 64'sd16777216;
    localparam longint SPEED_CAP = 64'd1099511627775;

    typedef struct {
        int f[9];
        bit obst;
        bit start;
        bit chk;
        int ef[9];
        longint esum;
        int ecnt;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [287:0] i_s_tdata;
    logic [1:0]   i_s_tuser;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [351:0] o_m_tdata;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [d2q9_bgk_pkg::RATE_W-1:0] i_cfg_data;

    // Predictor state: the running totals and omega as the core should hold them
    longint unsigned speed_total;
    int              fluid_total;
    longint          omega;

    d2q9_bgk_pkg::t_result cell_results_due[$];
    int      mismatches = 0;
    int      cycles = 0;
    bit      no_gaps;

    d2q9_bgk_collision_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // floor(a*b / 2^24) clamped to 32 bits, guarding against 64-bit overflow
    function automatic longint scaled_product(input longint a, input longint b);
        bit neg;
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned p;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        if (ma == 0 || mb == 0) return 0;
        if (mb > ((64'd1 << 56) - 1) / ma) return neg ? -64'sd2147483648 : 64'sd2147483647;
        p = ma * mb;
        if (!neg) return clamp32(longint'(p >> 24));
        return clamp32(-longint'((p + 64'd16777215) >> 24));
    endfunction

    // Collision of one cell: bounce-back or BGK relaxation, plus running totals
    function automatic d2q9_bgk_pkg::t_result collide_cell(input int f[9], input bit obst,
                                                           input bit start);
        int cx[9] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
        int cy[9] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
        int opp[9] = '{0, 3, 4, 1, 2, 7, 8, 5, 6};
        longint wt[9] = '{7456540, 1864135, 1864135, 1864135, 1864135,
                          466034, 466034, 466034, 466034};
        d2q9_bgk_pkg::t_result r;
        longint rho, mx, my, ux, uy, usq, half3, cu, t, br, wr, feq;
        longint unsigned sq;
        ux = 0;
        uy = 0;
        rho = 0;
        if (start) begin
            speed_total = 0;
            fluid_total = 0;
        end
        if (obst) begin
            for (int k = 0; k < 9; k++) r.f[k] = f[opp[k]];
        end else begin
            for (int k = 0; k < 9; k++) rho += longint'(f[k]);
            mx = longint'(f[1]) + f[5] + f[8] - f[3] - f[6] - f[7];
            my = longint'(f[2]) + f[5] + f[6] - f[4] - f[7] - f[8];
            if (rho != 0) begin
                ux = clamp32((mx * Q24) / rho);
                uy = clamp32((my * Q24) / rho);
            end
            sq = longint'(ux * ux) + longint'(uy * uy);
            usq = longint'(sq >> 24);
            half3 = (3 * usq) >>> 1;
            speed_total += int_sqrt(sq);
            if (speed_total > SPEED_CAP) speed_total = SPEED_CAP;
            if (fluid_total < d2q9_bgk_pkg::CNT_LIMIT) fluid_total++;
            for (int k = 0; k < 9; k++) begin
                cu = clamp32(cx[k] * ux + cy[k] * uy);
                t = longint'(longint'(cu * cu) >> 24);
                br = Q24 + 3 * cu + ((9 * t) >>> 1) - half3;
                wr = (wt[k] * rho) >>> 24;
                feq = scaled_product(wr, br);
                r.f[k] = 32'(clamp32(f[k] + ((omega * (feq - f[k])) >>> 24)));
            end
        end
        r.speed_sum = speed_total[d2q9_bgk_pkg::SUM_W-1:0];
        r.fluid_count = d2q9_bgk_pkg::CNT_W'(fluid_total);
        return r;
    endfunction

    function automatic bit take_gap();
        return !no_gaps && ($urandom_range(0, 99) < 31);
    endfunction

    // Offer one cell and wait for it to be taken
    task automatic drive_cell(input int f[9], input bit obst, input bit start,
                              input bit chk, input d2q9_bgk_pkg::t_result typed);
        d2q9_bgk_pkg::t_result due;
        while (take_gap()) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        for (int k = 0; k < 9; k++) i_s_tdata[32*k +: 32] <= f[k];
        i_s_tuser <= {start, obst};
        do @(posedge i_clk); while (!o_s_tready);
        due = collide_cell(f, obst, start);
        cell_results_due.push_back(chk ? typed : due);
    endtask

    // Write omega once all earlier cells have left the core
    task automatic set_relax_rate(input logic [d2q9_bgk_pkg::RATE_W-1:0] rate);
        i_s_tvalid <= 1'b0;
        while (cell_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= rate;
        do @(posedge i_clk); while (!o_cfg_ready);
        omega = rate;
        i_cfg_valid <= 1'b0;
    endtask

    // Random cell: near-equilibrium, fast flow, or plain noise
    task automatic random_cell(input int kind);
        int f[9];
        d2q9_bgk_pkg::t_result none;
        none = '0;
        for (int k = 0; k < 9; k++) begin
            case (kind)
                0: f[k] = $urandom();
                1: f[k] = int'($urandom_range(0, 8388608)) - 4194304
                        + ((k == 0) ? 8388608 : (k < 5 ? 2097152 : 524288));
                default: f[k] = int'($urandom_range(0, 65535)) - 32768;
            endcase
        end
        if (kind == 2) begin
            // Nearly cancelling distributions give a tiny density and a clamped speed
            f[1] = 32'sh7fffffff;
            f[3] = -32'sh7fffffff + 1;
            f[2] = 32'sh7fffffff;
            f[4] = -32'sh7fffffff + 1;
            f[0] = 0;
        end
        drive_cell(f, (kind != 2) && ($urandom_range(0, 99) < 30),
                   (kind != 2) && ($urandom_range(0, 99) < 4), 1'b0, none);
    endtask

    // Result side: random back-pressure and comparison with the oldest prediction
    always @(posedge i_clk) begin
        d2q9_bgk_pkg::t_result got;
        d2q9_bgk_pkg::t_result want;
        bit bad;
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            i_m_tready <= no_gaps || ($urandom_range(0, 99) >= 31);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                got = o_m_tdata[$bits(d2q9_bgk_pkg::t_result)-1:0];
                bad = 1'b0;
                if (cell_results_due.size() == 0) begin
                    bad = 1'b1;
                    want = '0;
                end else begin
                    want = cell_results_due.pop_front();
                    for (int k = 0; k < 9; k++) if (got.f[k] !== want.f[k]) bad = 1'b1;
                    if (got.speed_sum !== want.speed_sum) bad = 1'b1;
                    if (got.fluid_count !== want.fluid_count) bad = 1'b1;
                end
                if (bad) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) begin
                        $display("mismatch at cycle %0d: expected %h", cycles, want);
                        $display("                      actual   %h", got);
                    end
                end
            end
        end
    end

    initial begin
        t_row rows[12];
        d2q9_bgk_pkg::t_result typed;
        logic [d2q9_bgk_pkg::RATE_W-1:0] rates[5];
        rows[0]  = '{'{1,2,3,4,5,6,7,8,9}, 1, 0, 1, '{1,4,5,2,3,8,9,6,7}, 0, 0};
        rows[1]  = '{'{0,0,0,0,0,0,0,0,0}, 0, 1, 1, '{0,0,0,0,0,0,0,0,0}, 0, 1};
        rows[2]  = '{'{default: 32'sh7fffffff}, 1, 0, 1, '{default: 32'sh7fffffff}, 0, 1};
        rows[3]  = '{'{default: 32'sh80000000}, 1, 1, 1, '{default: 32'sh80000000}, 0, 0};
        rows[4]  = '{'{16777216,0,0,0,0,0,0,0,0}, 0, 0, 0, '{default: 0}, 0, 0};
        rows[5]  = '{'{default: 32'sh7fffffff}, 0, 0, 0, '{default: 0}, 0, 0};
        rows[6]  = '{'{default: 32'sh80000000}, 0, 0, 0, '{default: 0}, 0, 0};
        rows[7]  = '{'{0,32'sh7fffffff,32'sh7fffffff,32'sh80000000,32'sh80000000,
                       32'sh7fffffff,0,32'sh80000000,0}, 0, 0, 0, '{default: 0}, 0, 0};
        rows[8]  = '{'{-16777216,2000000,-3000000,0,5,0,0,0,-1}, 0, 0, 0,
                     '{default: 0}, 0, 0};
        rows[9]  = '{'{7456540,2500000,1864135,1300000,1864135,700000,300000,
                       466034,466034}, 0, 0, 0, '{default: 0}, 0, 0};
        rows[10] = '{'{1,2,3,4,5,6,7,8,9}, 1, 1, 1, '{1,4,5,2,3,8,9,6,7}, 0, 0};
        rows[11] = '{'{1,-1,1,-1,1,-1,1,-1,0}, 0, 0, 0, '{default: 0}, 0, 0};
        rates = '{26'd0, 26'd33554432, 26'h3ffffff, 26'd0, 26'd16777216};

        no_gaps = 1'b0;
        speed_total = 0;
        fluid_total = 0;
        omega = 16777216;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed cells at the reset value of omega
        foreach (rows[i]) begin
            typed = '0;
            for (int k = 0; k < 9; k++) typed.f[k] = rows[i].ef[k];
            typed.speed_sum = rows[i].esum[d2q9_bgk_pkg::SUM_W-1:0];
            typed.fluid_count = d2q9_bgk_pkg::CNT_W'(rows[i].ecnt);
            drive_cell(rows[i].f, rows[i].obst, rows[i].start, rows[i].chk, typed);
        end

        // Random phases over several relaxation rates
        for (int p = 0; p < 5; p++) begin
            set_relax_rate((p == 3) ? d2q9_bgk_pkg::RATE_W'($urandom()) : rates[p]);
            if (p == 2) begin
                // Steady fast flow long enough to saturate the speed sum
                no_gaps = 1'b1;
                for (int i = 0; i < 380; i++) random_cell(2);
                no_gaps = 1'b0;
            end
            for (int i = 0; i < 300; i++) random_cell((i % 5 == 0) ? 0 : 1);
        end

        i_s_tvalid <= 1'b0;
        while (cell_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
